### design/swsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the shader word stream packer.
package swsp_pkg;

   localparam logic [31:0] MAGIC_IN   = 32'h0723_0203;
   localparam logic [31:0] MAGIC_OUT  = 32'h534D_4F4C;
   localparam logic [31:0] VERSION_A  = 32'h0001_0000;
   localparam logic [31:0] VERSION_B  = 32'h0001_0100;
   localparam logic [15:0] SHORT_FLAG = 16'h8000;
   localparam logic [15:0] SHORT_LEN_LIM = 16'd32;
   localparam logic [15:0] SHORT_OP_LIM  = 16'd1024;

   // header word positions; HDR_BODY means instruction stream
   localparam logic [2:0] HDR_MAGIC   = 3'd0;
   localparam logic [2:0] HDR_VERSION = 3'd1;
   localparam logic [2:0] HDR_FINAL   = 3'd4;
   localparam logic [2:0] HDR_BODY    = 3'd5;

   // byte-count codes (index of the last byte of a command)
   localparam logic [1:0] LAST_IDX_ONE  = 2'd0;
   localparam logic [1:0] LAST_IDX_TWO  = 2'd1;
   localparam logic [1:0] LAST_IDX_FOUR = 2'd3;

   localparam int QDepth = 4;
   localparam int QAddrW = $clog2(QDepth);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_HEADER   = 2'd1,
      STATUS_ZERO_LEN = 2'd2,
      STATUS_TRUNC    = 2'd3
   } status_type;

   // one command from the classifier: a word and how many of its bytes go out
   typedef struct packed {
      logic [31:0] data;
      logic [1:0]  last_idx;
      status_type  status;
   } cmd_type;

endpackage

### design/swsp_front.sv
`timescale 1ns / 1ps
// Front end: tracks module position, classifies each word and issues byte commands.
module swsp_front import swsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        word_valid,
   input  logic [31:0] in_word,
   input  logic        last_word,
   output logic        cmd_push,
   output cmd_type     cmd
);

   logic [2:0]  header_index_ff, header_index_in;
   logic [15:0] words_remaining_ff, words_remaining_in;
   logic        skipping_ff, skipping_in;

   logic [15:0] len;
   logic [15:0] op;
   logic        emit;

   assign len = in_word[31:16];
   assign op  = in_word[15:0];

   always_comb begin
      header_index_in    = header_index_ff;
      words_remaining_in = words_remaining_ff;
      skipping_in        = skipping_ff;
      emit               = 1'b0;
      cmd.data           = in_word;
      cmd.last_idx       = LAST_IDX_FOUR;
      cmd.status         = STATUS_OK;

      if (skipping_ff) begin
         // discard until the last word, which gives nothing either
      end else if (header_index_ff < HDR_BODY) begin
         emit = 1'b1;
         if ((last_word && header_index_ff < HDR_FINAL)
               || (header_index_ff == HDR_MAGIC && in_word != MAGIC_IN)
               || (header_index_ff == HDR_VERSION && in_word != VERSION_A
                   && in_word != VERSION_B)) begin
            cmd.data     = '0;
            cmd.last_idx = LAST_IDX_ONE;
            cmd.status   = STATUS_HEADER;
            skipping_in  = 1'b1;
         end else begin
            if (header_index_ff == HDR_MAGIC) begin
               cmd.data = MAGIC_OUT;
            end
            header_index_in = header_index_ff + 3'd1;
         end
      end else if (words_remaining_ff == '0) begin
         emit = 1'b1;
         if (len == '0) begin
            cmd.data     = '0;
            cmd.last_idx = LAST_IDX_ONE;
            cmd.status   = STATUS_ZERO_LEN;
            skipping_in  = 1'b1;
         end else if (last_word && len > 16'd1) begin
            cmd.data     = '0;
            cmd.last_idx = LAST_IDX_ONE;
            cmd.status   = STATUS_TRUNC;
         end else begin
            if (len < SHORT_LEN_LIM && op < SHORT_OP_LIM) begin
               cmd.data     = {16'h0000, SHORT_FLAG | {1'b0, len[4:0], op[9:0]}};
               cmd.last_idx = LAST_IDX_TWO;
            end
            words_remaining_in = len - 16'd1;
         end
      end else begin
         emit = 1'b1;
         if (last_word && words_remaining_ff > 16'd1) begin
            cmd.data     = '0;
            cmd.last_idx = LAST_IDX_ONE;
            cmd.status   = STATUS_TRUNC;
         end else begin
            words_remaining_in = words_remaining_ff - 16'd1;
         end
      end

      // end of module: everything back to the start
      if (last_word) begin
         header_index_in    = HDR_MAGIC;
         words_remaining_in = '0;
         skipping_in        = 1'b0;
      end
   end

   assign cmd_push = word_valid && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_index_ff    <= HDR_MAGIC;
         words_remaining_ff <= '0;
         skipping_ff        <= 1'b0;
      end else if (word_valid) begin
         header_index_ff    <= header_index_in;
         words_remaining_ff <= words_remaining_in;
         skipping_ff        <= skipping_in;
      end
   end

endmodule

### design/swsp_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the byte serializer.
module swsp_queue import swsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty
);

   cmd_type             entry_ff [QDepth];
   logic [QAddrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAddrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAddrW:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == QDepth[QAddrW:0]);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QAddrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QAddrW'(1) : rd_ptr_ff;
      count_in  = count_ff + {{QAddrW{1'b0}}, do_push} - {{QAddrW{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### design/swsp_back.sv
`timescale 1ns / 1ps
// Back end: splits queued commands into bytes, least significant first, into the output register.
module swsp_back import swsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head_cmd,
   input  logic       head_empty,
   output logic       head_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end,
   output logic [1:0] rsp_status
);

   logic [1:0] byte_idx_ff, byte_idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       run_end_ff;
   status_type status_ff;
   logic       load;
   logic       is_last;

   // output register takes a new byte when it is free or being drained
   assign load    = (!valid_ff || rsp_pop) && !head_empty;
   assign is_last = (byte_idx_ff == head_cmd.last_idx);
   assign head_pop = load && is_last;

   always_comb begin
      byte_idx_in = byte_idx_ff;
      valid_in    = valid_ff;
      if (!valid_ff || rsp_pop) begin
         valid_in = !head_empty;
      end
      if (load) begin
         byte_idx_in = is_last ? 2'd0 : byte_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_idx_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         byte_idx_ff <= byte_idx_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff    <= head_cmd.data[{byte_idx_ff, 3'b000} +: 8];
         run_end_ff <= is_last;
         status_ff  <= head_cmd.status;
      end
   end

   assign rsp_empty    = !valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_end  = run_end_ff;
   assign rsp_status   = status_ff;

endmodule

### design/shader_word_stream_packer.sv
`timescale 1ns / 1ps
// Top level of the shader word stream packer: 32-bit module words in, packed bytes out.
//
//   channel   ports                                  transfer when
//   -------   ------------------------------------   --------------------
//   request   req_in_word, req_last_word             req_push && !req_full
//   response  rsp_out_byte, rsp_run_end, rsp_status  rsp_pop && !rsp_empty
//
// The front end takes one word per cycle while the command queue has room.
// The back end sends one byte per cycle while the receiver pops: header, operand and
// unpacked instruction words give 4 bytes, packed headers 2, errors 1, skipped words none.
// The first byte of a word passes through the command queue and then the output register.
// Synchronous reset empties the queue and output register and restarts at
// header word 0. A stalled response fills the queue, then raises req_full.
module shader_word_stream_packer import swsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_in_word,
   input  logic        req_last_word,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_end,
   output logic [1:0]  rsp_status
);

   logic    word_valid;
   logic    cmd_push;
   cmd_type cmd;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   cmd_type head_cmd;

   assign req_full   = q_full;
   assign word_valid = req_push && !q_full;

   swsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .word_valid (word_valid),
      .in_word    (req_in_word),
      .last_word  (req_last_word),
      .cmd_push   (cmd_push),
      .cmd        (cmd)
   );

   swsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   swsp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .head_empty   (q_empty),
      .head_pop     (q_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_end  (rsp_run_end),
      .rsp_status   (rsp_status)
   );

endmodule

### design/swsp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the shader word stream packer, bound to the top level.
module swsp_checker import swsp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic [31:0] req_in_word,
   input logic        req_last_word,
   input logic        rsp_pop,
   input logic        rsp_empty,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_run_end,
   input logic [1:0]  rsp_status
);

   // after reset nothing is waiting and there is room
   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("outputs not cleared by reset");

   // an error is a single result of its own
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != STATUS_OK) |-> rsp_run_end)
      else $error("error result is not a whole run");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != STATUS_OK) |-> rsp_out_byte == 8'h00)
      else $error("error result carries a nonzero byte");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_out_byte)
         && $stable(rsp_run_end) && $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind shader_word_stream_packer swsp_checker u_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the shader word stream packer: modules in, packed bytes checked.
module tb_top;
   import swsp_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef logic [31:0] word_q_type[$];

   typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      status_type status;
   } out_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [31:0] req_in_word = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_pop = 1'b0;
   logic        rsp_empty;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_end;
   logic [1:0]  rsp_status;

   // packer state mirror
   logic [2:0]  hdr_pos;
   logic [15:0] ops_owed;
   logic        skip_rest;

   out_byte_type expected_bytes[$];
   logic        in_taken = 1'b0;
   logic        out_taken = 1'b0;
   bit          sender_idles = 1'b1;
   bit          receiver_idles = 1'b1;
   int          quiet_cycles = 0;
   int          error_count = 0;
   int          words_used = 0;
   int          module_count = 0;
   int          bytes_checked = 0;
   int          error_results = 0;

   shader_word_stream_packer i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_in_word   (req_in_word),
      .req_last_word (req_last_word),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_end   (rsp_run_end),
      .rsp_status    (rsp_status)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void end_of_module();
      hdr_pos   = HDR_MAGIC;
      ops_owed  = '0;
      skip_rest = 1'b0;
   endfunction

   function automatic void push_bytes(input logic [31:0] value, input int count);
      out_byte_type item;
      for (int k = 0; k < count; k++) begin
         item = '{value[8*k +: 8], k == count - 1, STATUS_OK};
         expected_bytes.insert(expected_bytes.size(), item);
      end
   endfunction

   function automatic void push_error(input status_type code, input logic lst);
      out_byte_type item;
      item = '{8'h00, 1'b1, code};
      expected_bytes.insert(expected_bytes.size(), item);
      if (lst)
         end_of_module();
      else
         skip_rest = 1'b1;
   endfunction

   function automatic void pack_word(input logic [31:0] w, input logic lst);
      logic [15:0] len;
      logic [15:0] op;
      logic [15:0] short_hdr;
      if (skip_rest) begin
         if (lst)
            end_of_module();
         return;
      end
      words_used++;
      if (hdr_pos < HDR_BODY) begin
         if (lst && hdr_pos < HDR_FINAL) begin
            push_error(STATUS_HEADER, 1'b1);
            return;
         end
         if (hdr_pos == HDR_MAGIC) begin
            if (w != MAGIC_IN) begin
               push_error(STATUS_HEADER, lst);
               return;
            end
            push_bytes(MAGIC_OUT, 4);
         end else if (hdr_pos == HDR_VERSION) begin
            if (w != VERSION_A && w != VERSION_B) begin
               push_error(STATUS_HEADER, lst);
               return;
            end
            push_bytes(w, 4);
         end else begin
            push_bytes(w, 4);
         end
         hdr_pos = hdr_pos + 3'd1;
         if (lst)
            end_of_module();
         return;
      end
      if (ops_owed == 0) begin
         len = w[31:16];
         op  = w[15:0];
         if (len == 0) begin
            push_error(STATUS_ZERO_LEN, lst);
            return;
         end
         if (lst && len > 1) begin
            push_error(STATUS_TRUNC, 1'b1);
            return;
         end
         if (len < SHORT_LEN_LIM && op < SHORT_OP_LIM) begin
            short_hdr = SHORT_FLAG | (len << 10) | op;
            push_bytes({16'h0000, short_hdr}, 2);
         end else begin
            push_bytes(w, 4);
         end
         ops_owed = len - 16'd1;
      end else begin
         if (lst && ops_owed > 1) begin
            push_error(STATUS_TRUNC, 1'b1);
            return;
         end
         push_bytes(w, 4);
         ops_owed = ops_owed - 16'd1;
      end
      if (lst)
         end_of_module();
   endfunction

   // ------------------------------------------------- monitor, checker, watchdog

   always @(posedge clock) begin
      out_byte_type want;
      in_taken  = !reset && req_push && !req_full;
      out_taken = !reset && rsp_pop && !rsp_empty;
      if (in_taken)
         pack_word(req_in_word, req_last_word);
      if (out_taken) begin
         bytes_checked++;
         if (rsp_status != STATUS_OK)
            error_results++;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected transfer byte %02h end %0b status %0d, nothing expected",
                     $realtime, rsp_out_byte, rsp_run_end, rsp_status);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.data || rsp_run_end !== want.run_end ||
                rsp_status !== want.status) begin
               $display("%0t: mismatch expected byte %02h end %0b status %0d, got %02h %0b %0d",
                        $realtime, want.data, want.run_end, want.status,
                        rsp_out_byte, rsp_run_end, rsp_status);
               error_count++;
            end
         end
      end
      if (!reset) begin
         if (in_taken || out_taken)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d bytes still owed",
                     $realtime, quiet_cycles, expected_bytes.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // receiver: pops with random stalls unless receiver_idles is cleared
   always @(negedge clock) begin
      if (reset)
         rsp_pop = 1'b0;
      else if (receiver_idles)
         rsp_pop = ($urandom_range(99) >= 34);
      else
         rsp_pop = 1'b1;
   end

   // ------------------------------------------------------------------ sender

   task automatic send_word(input logic [31:0] w, input logic lst);
      if (sender_idles)
         while ($urandom_range(99) < 34)
            @(negedge clock);
      req_push      = 1'b1;
      req_in_word   = w;
      req_last_word = lst;
      do @(negedge clock); while (!in_taken);
      req_push = 1'b0;
   endtask

   task automatic send_module(input word_q_type words);
      foreach (words[i])
         send_word(words[i], i == words.size() - 1);
      module_count++;
   endtask

   task automatic add_header(ref word_q_type q, input logic [31:0] ver);
      q.insert(q.size(), MAGIC_IN);
      q.insert(q.size(), ver);
      repeat (3) q.insert(q.size(), $urandom);
   endtask

   task automatic wait_drained();
      while (expected_bytes.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------- tests

   task automatic test_header_checks();
      word_q_type q;
      // header-only module ends normally on word 4
      q = '{MAGIC_IN, VERSION_B, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678};
      send_module(q);
      // ends on word 0 and on word 3
      q = '{MAGIC_IN};
      send_module(q);
      q = '{MAGIC_IN, VERSION_A, 32'h0000_0001, 32'h0000_0002};
      send_module(q);
      // bad magic, then the rest is skipped
      q = '{MAGIC_OUT, 32'hDEAD_BEEF, 32'h0001_0000};
      send_module(q);
      // bad version
      q = '{MAGIC_IN, 32'h0001_0200, 32'h0000_0007};
      send_module(q);
   endtask

   task automatic test_instruction_packing();
      word_q_type q;
      q = {};
      add_header(q, VERSION_A);
      q.insert(q.size(), 32'h0001_0000);    // shortest packed form
      q.insert(q.size(), 32'h0002_03FF);    // largest packed opcode
      q.insert(q.size(), 32'hFFFF_FFFF);
      q.insert(q.size(), 32'h0001_0400);    // opcode too big to pack
      q.insert(q.size(), 32'hFFFF_FFFF);    // huge length, cut short by the last word
      send_module(q);
   endtask

   task automatic send_random_module();
      word_q_type q;
      int      n_instr;
      int      len;
      int      cut;
      logic [15:0] op;
      q = {};
      add_header(q, $urandom_range(1) ? VERSION_A : VERSION_B);
      n_instr = $urandom_range(0, 6);
      repeat (n_instr) begin
         case ($urandom_range(9))
            0:       len = $urandom_range(5, 40);
            1:       len = $urandom_range(30, 33);
            default: len = $urandom_range(1, 4);
         endcase
         op = ($urandom_range(9) < 6) ? 16'($urandom_range(0, 1023)) : 16'($urandom);
         q.insert(q.size(), {16'(len), op});
         repeat (len - 1) q.insert(q.size(), $urandom);
      end
      if ($urandom_range(99) < 22) begin
         case ($urandom_range(5))
            0: q[0] = $urandom;
            1: q[1] = $urandom;
            2: begin
               cut = $urandom_range(1, q.size() - 1);
               while (q.size() > cut) void'(q.pop_back());
            end
            3: begin
               q.insert(q.size(), {16'h0000, 16'($urandom)});
               repeat ($urandom_range(0, 3)) q.insert(q.size(), $urandom);
            end
            4: begin
               q.insert(q.size(), {16'($urandom_range(2, 16'hFFFF)), 16'($urandom)});
               repeat ($urandom_range(0, 3)) q.insert(q.size(), $urandom);
            end
            default: begin
               q = {};
               repeat ($urandom_range(1, 6)) q.insert(q.size(), $urandom);
            end
         endcase
      end
      send_module(q);
   endtask

   task automatic test_random_modules(input int target);
      int start;
      start = words_used;
      while (words_used - start < target)
         send_random_module();
   endtask

   task automatic test_drain_pause();
      test_random_modules(30);
      wait_drained();
      test_random_modules(30);
   endtask

   task automatic test_no_idle_stretch();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      test_random_modules(80);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   initial begin
      end_of_module();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_header_checks();
      test_instruction_packing();
      test_random_modules(150);
      test_drain_pause();
      test_no_idle_stretch();
      test_random_modules(100);
      wait_drained();
      repeat (16) @(negedge clock);
      $display("Sent %0d modules, %0d words reaching the packer", module_count, words_used);
      $display("Checked %0d output bytes, %0d of them error reports", bytes_checked,
               error_results);
      if (error_count == 0 && expected_bytes.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
design/swsp_pkg.sv
design/swsp_front.sv
design/swsp_queue.sv
design/swsp_back.sv
design/shader_word_stream_packer.sv
design/swsp_checker.sv
sim/tb_top.sv
